// ===== sv/lcg_shuffle_cbc_block_decrypt_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LCG shuffle CBC block decrypter
// Assertions compile away under SYNTH.
// ----------------------------------------------------------------------------
`ifndef LCG_SHUFFLE_CBC_BLOCK_DECRYPT_MACROS_SVH
`define LCG_SHUFFLE_CBC_BLOCK_DECRYPT_MACROS_SVH
`ifndef SYNTH
`define LSCBD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LSCBD_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LSCBD_ASSERT(label, clk, rst_n, prop, msg)
`define LSCBD_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/lscbd_pkg.sv =====
// ----------------------------------------------------------------------------
// lscbd_pkg
// Types, constants and helpers of the LCG shuffle CBC block decrypter.
// ----------------------------------------------------------------------------
package lscbd_pkg;
	localparam int unsigned NBYTES = 16;
	localparam int unsigned QDEPTH = 2;
	localparam logic [7:0] LCG_MUL = 8'h6d; // 1103515245 mod 256
	localparam logic [7:0] LCG_ADD = 8'h39; // 12345 mod 256
	localparam logic [4:0] FULL_CNT = 5'd16;

	typedef logic [7:0] byte_t;
	typedef byte_t [NBYTES-1:0] block_t;

	typedef struct packed {
		block_t ct;
		logic   restart;
		logic   last_block;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_IV, ST_KS, ST_SWAP, ST_DONE
	} state_t;

	function automatic byte_t lcg_next(byte_t g);
		logic [15:0] p;
		p = g * LCG_MUL;
		return p[7:0] + LCG_ADD;
	endfunction
endpackage

// ===== sv/lscbd_front.sv =====
// ----------------------------------------------------------------------------
// lscbd_front
// Accepts blocks and queues them as jobs for the back end.
// ----------------------------------------------------------------------------
`include "lcg_shuffle_cbc_block_decrypt_macros.svh"

module lscbd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [63:0]        ct_low,
	input  logic [63:0]        ct_high,
	input  logic               restart,
	input  logic               last_block,
	output logic               job_valid,
	output lscbd_pkg::job_t    job,
	input  logic               job_take
);
	import lscbd_pkg::*;

	job_t       mem_q [QDEPTH];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign full      = (cnt_q == 2'(QDEPTH));
	assign job_valid = (cnt_q != 2'd0);
	assign wr        = push && !full;
	assign rd        = job_take && job_valid;
	assign job       = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= '{ct: {ct_high, ct_low}, restart: restart, last_block: last_block};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	`LSCBD_NEVER(a_no_overflow, clk, arst_n, cnt_q > 2'(QDEPTH), "job queue overflow")
	`LSCBD_ASSERT(a_count, clk, arst_n, (wr && !rd) |=> cnt_q == $past(cnt_q) + 2'd1, "count")
	`LSCBD_ASSERT(a_drain, clk, arst_n, (rd && !wr) |=> cnt_q == $past(cnt_q) - 2'd1, "drain")
endmodule

// ===== sv/lscbd_back.sv =====
// ----------------------------------------------------------------------------
// lscbd_back
// Runs the generator, unshuffles, applies CBC and holds one result.
// ----------------------------------------------------------------------------
`include "lcg_shuffle_cbc_block_decrypt_macros.svh"

module lscbd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            job_valid,
	input  lscbd_pkg::job_t job,
	output logic            job_take,
	output logic            empty,
	input  logic            pop,
	output logic [63:0]     pt_low,
	output logic [63:0]     pt_high,
	output logic [4:0]      valid_bytes,
	output logic            pad_error
);
	import lscbd_pkg::*;

	state_t state_q, state_d;
	byte_t  seed_q, gen_q, gen_n;
	block_t prev_q, work_q, ks_q, ct_q;
	logic   last_q;
	logic [3:0] idx_q;
	logic   out_full_q;
	block_t pt_q;
	logic [4:0] vb_q;
	logic   perr_q;
	block_t pt_c;
	byte_t  ta, tb;
	logic [3:0] sa, sb;

	assign gen_n = lcg_next(gen_q);
	assign sa = ks_q[idx_q][3:0];
	assign sb = ks_q[idx_q][7:4];
	assign ta = work_q[sa];
	assign tb = work_q[sb];

	always_comb begin
		for (int i = 0; i < NBYTES; i++) pt_c[i] = work_q[i] ^ prev_q[i];
	end

	always_comb begin
		state_d  = state_q;
		job_take = 1'b0;
		unique case (state_q)
			ST_IDLE: if (job_valid) begin
				job_take = 1'b1;
				state_d  = job.restart ? ST_IV : ST_KS;
			end
			ST_IV:   if (idx_q == 4'hf) state_d = ST_KS;
			ST_KS:   if (idx_q == 4'hf) state_d = ST_SWAP;
			ST_SWAP: if (idx_q == 4'h0) state_d = ST_DONE;
			ST_DONE: if (!out_full_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seed_q     <= '0;
			gen_q      <= '0;
			prev_q     <= '0;
			idx_q      <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) seed_q <= cfg_wdata;
			if (pop && out_full_q) out_full_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (job_valid && job.restart) gen_q <= seed_q;
				end
				ST_IV: begin
					gen_q         <= gen_n;
					prev_q[idx_q] <= gen_n;
					idx_q         <= idx_q + 4'd1;
				end
				ST_KS: begin
					gen_q <= gen_n;
					// hold at the top index so the swaps start from byte 15
					if (idx_q != 4'hf) idx_q <= idx_q + 4'd1;
				end
				ST_SWAP: idx_q <= idx_q - 4'd1;
				ST_DONE: if (!out_full_q) begin
					prev_q     <= ct_q;
					out_full_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job_valid) begin
			ct_q   <= job.ct;
			last_q <= job.last_block;
		end
		if (state_q == ST_KS) begin
			ks_q[idx_q]   <= gen_n;
			work_q[idx_q] <= ct_q[idx_q] ^ gen_n;
		end
		if (state_q == ST_SWAP) begin
			work_q[sa] <= tb;
			work_q[sb] <= ta;
		end
		if (state_q == ST_DONE && !out_full_q) begin
			pt_q <= pt_c;
			if (!last_q) begin
				vb_q <= FULL_CNT; perr_q <= 1'b0;
			end else if (pt_c[15] > 8'(FULL_CNT)) begin
				vb_q <= '0; perr_q <= 1'b1;
			end else begin
				vb_q <= FULL_CNT - pt_c[15][4:0]; perr_q <= 1'b0;
			end
		end
	end

	assign empty       = !out_full_q;
	assign pt_low      = pt_q[7:0];
	assign pt_high     = pt_q[15:8];
	assign valid_bytes = vb_q;
	assign pad_error   = perr_q;

	`LSCBD_ASSERT(a_take_idle, clk, arst_n, job_take |-> state_q == ST_IDLE, "take outside idle")
	`LSCBD_ASSERT(a_err_zero, clk, arst_n, (out_full_q && pad_error) |-> valid_bytes == 5'd0, "pad")
	`LSCBD_ASSERT(a_hold, clk, arst_n, (out_full_q && !pop) |=> out_full_q && $stable(pt_q), "hold")
endmodule

// ===== sv/lcg_shuffle_cbc_block_decrypt.sv =====
// ----------------------------------------------------------------------------
// lcg_shuffle_cbc_block_decrypt
// Each block runs 16 keystream steps, then 16 swaps; a restart first generates the IV.
// The back end finishes one block before it takes the next, with a single generator and swap unit.
// A two-entry job queue accepts new blocks while the back end works.
// Reset clears seed, generator and previous block to zero.
// ----------------------------------------------------------------------------
module lcg_shuffle_cbc_block_decrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [63:0] ct_low,
	input  logic [63:0] ct_high,
	input  logic        restart,
	input  logic        last_block,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] pt_low,
	output logic [63:0] pt_high,
	output logic [4:0]  valid_bytes,
	output logic        pad_error
);
	import lscbd_pkg::*;

	logic job_valid, job_take;
	job_t job;

	lscbd_front u_front (
		.clk, .arst_n, .push, .full, .ct_low, .ct_high, .restart, .last_block,
		.job_valid, .job, .job_take
	);

	lscbd_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .job_valid, .job, .job_take,
		.empty, .pop, .pt_low, .pt_high, .valid_bytes, .pad_error
	);
endmodule
